[sv/escape_string_to_serial_bytes_unit_defines.svh]
// Assertion macros for the escape string decoder.
`ifndef ESCAPE_STRING_TO_SERIAL_BYTES_UNIT_DEFINES_SVH
`define ESCAPE_STRING_TO_SERIAL_BYTES_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, off during reset.
`define ESSB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, checked during reset too.
`define ESSB_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ESSB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ESSB_ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

[sv/essb_pkg.sv]
package essb_pkg;

  localparam logic [7:0] CH_DEC_OPEN  = 8'h5B;
  localparam logic [7:0] CH_DEC_CLOSE = 8'h5D;
  localparam logic [7:0] CH_HEX_OPEN  = 8'h7B;
  localparam logic [7:0] CH_HEX_CLOSE = 8'h7D;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_DELAY     = 8'h5E;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_DEC_OPEN,
    CLS_DEC_CLOSE,
    CLS_HEX_OPEN,
    CLS_HEX_CLOSE,
    CLS_QUOTE,
    CLS_DELAY,
    CLS_OTHER
  } char_cls_t;

  // Character after classification, as it waits in the queue.
  typedef struct packed {
    char_cls_t  cls;
    logic       dec_digit;
    logic       hex_digit;
    logic [3:0] digit_val;
    logic [7:0] char_code;
    logic       last_char;
  } class_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_DEC       = 3'd1,
    MODE_HEX       = 3'd2,
    MODE_TEXT      = 3'd3,
    MODE_AFTER_DEC = 3'd4,
    MODE_AFTER_HEX = 3'd5
  } mode_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/essb_front.sv]
module essb_front import essb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  in_item_t    char_item,
  output logic        q_push,
  input  logic        q_ready,
  output class_item_t q_item
);

  logic        stage_valid;
  class_item_t stage;
  class_item_t classed;
  logic        accept;
  logic        is_num;
  logic        is_upper;
  logic        is_lower;

  assign char_stall = stage_valid && !q_ready;
  assign accept     = char_valid && !char_stall;
  assign q_push     = stage_valid && q_ready;
  assign q_item     = stage;

  assign is_num   = (char_item.char_code >= 8'h30) && (char_item.char_code <= 8'h39);
  assign is_upper = (char_item.char_code >= 8'h41) && (char_item.char_code <= 8'h46);
  assign is_lower = (char_item.char_code >= 8'h61) && (char_item.char_code <= 8'h66);

  always_comb begin
    classed.char_code = char_item.char_code;
    classed.last_char = char_item.last_char;
    classed.dec_digit = is_num;
    classed.hex_digit = is_num || is_upper || is_lower;
    // letters a-f / A-F: low nibble 1..6 maps to 10..15
    classed.digit_val = is_num ? char_item.char_code[3:0]
                               : 4'(char_item.char_code[3:0] + 4'd9);
    unique case (char_item.char_code)
      CH_DEC_OPEN:  classed.cls = CLS_DEC_OPEN;
      CH_DEC_CLOSE: classed.cls = CLS_DEC_CLOSE;
      CH_HEX_OPEN:  classed.cls = CLS_HEX_OPEN;
      CH_HEX_CLOSE: classed.cls = CLS_HEX_CLOSE;
      CH_QUOTE:     classed.cls = CLS_QUOTE;
      CH_DELAY:     classed.cls = CLS_DELAY;
      default:      classed.cls = CLS_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= classed;
    end
  end

endmodule

[sv/essb_queue.sv]
module essb_queue import essb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  class_item_t   push_data,
  input  logic          pop,
  output class_item_t   pop_data,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  class_item_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/essb_back.sv]
module essb_back import essb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  class_item_t q_item,
  output logic        res_valid,
  input  logic        res_stall,
  output out_item_t   res_item
);

  mode_t       mode;
  logic [1:0]  cnt;
  logic [7:0]  acc;

  mode_t       mode_step;
  logic [1:0]  cnt_step;
  logic [7:0]  acc_step;

  logic        emit_step;
  logic        kind_step;
  logic [7:0]  byte_step;
  logic        res_emit;
  logic [7:0]  res_byte;

  logic [1:0]  level;
  logic [10:0] acc_mul;
  logic [7:0]  acc_dec;
  logic [7:0]  acc_hex;
  logic        dec_full;
  logic        hex_full;
  logic        opens_dec;
  logic        opens_hex;

  assign q_pop = q_valid && (!res_valid || !res_stall);

  // acc * 10 + digit, modulo 256
  assign acc_mul  = {acc, 3'b000} + {2'b00, acc, 1'b0} + {7'b0000000, q_item.digit_val};
  assign acc_dec  = acc_mul[7:0];
  assign acc_hex  = {acc[3:0], q_item.digit_val};
  assign dec_full = (cnt >= 2'd2);
  assign hex_full = (cnt >= 2'd1);

  // which forms may open: 0 all, 1 no decimal, 2 text and delay only
  always_comb begin
    unique case (mode)
      MODE_AFTER_DEC: level = 2'd1;
      MODE_AFTER_HEX: level = 2'd2;
      default:        level = 2'd0;
    endcase
  end

  assign opens_dec = (level == 2'd0) && (q_item.cls == CLS_DEC_OPEN);
  assign opens_hex = (level <= 2'd1) && (q_item.cls == CLS_HEX_OPEN);

  // next state
  always_comb begin
    mode_step = mode;
    cnt_step  = cnt;
    acc_step  = acc;
    unique case (mode)
      MODE_DEC: begin
        if (q_item.cls == CLS_DEC_CLOSE) begin
          mode_step = MODE_IDLE;
          cnt_step  = '0;
          acc_step  = '0;
        end else if (q_item.dec_digit) begin
          if (dec_full) begin
            mode_step = MODE_AFTER_DEC;
            cnt_step  = '0;
            acc_step  = '0;
          end else begin
            cnt_step = 2'(cnt + 2'd1);
            acc_step = acc_dec;
          end
        end
      end
      MODE_HEX: begin
        if (q_item.cls == CLS_HEX_CLOSE) begin
          mode_step = MODE_IDLE;
          cnt_step  = '0;
          acc_step  = '0;
        end else if (q_item.hex_digit) begin
          if (hex_full) begin
            mode_step = MODE_AFTER_HEX;
            cnt_step  = '0;
            acc_step  = '0;
          end else begin
            cnt_step = 2'(cnt + 2'd1);
            acc_step = acc_hex;
          end
        end
      end
      MODE_TEXT: begin
        if (q_item.cls == CLS_QUOTE) begin
          mode_step = MODE_IDLE;
          cnt_step  = '0;
          acc_step  = '0;
        end
      end
      default: begin
        cnt_step = '0;
        acc_step = '0;
        if (opens_dec) begin
          mode_step = MODE_DEC;
        end else if (opens_hex) begin
          mode_step = MODE_HEX;
        end else if (q_item.cls == CLS_QUOTE) begin
          mode_step = MODE_TEXT;
        end else begin
          mode_step = MODE_IDLE;
        end
      end
    endcase
  end

  // result of this character
  always_comb begin
    emit_step = 1'b0;
    kind_step = 1'b0;
    byte_step = '0;
    unique case (mode)
      MODE_DEC: begin
        if (q_item.cls == CLS_DEC_CLOSE) begin
          emit_step = 1'b1;
          byte_step = acc;
        end else if (q_item.dec_digit && dec_full) begin
          emit_step = 1'b1;
          byte_step = acc_dec;
        end
      end
      MODE_HEX: begin
        if (q_item.cls == CLS_HEX_CLOSE) begin
          emit_step = 1'b1;
          byte_step = acc;
        end else if (q_item.hex_digit && hex_full) begin
          emit_step = 1'b1;
          byte_step = acc_hex;
        end
      end
      MODE_TEXT: begin
        if (q_item.cls != CLS_QUOTE) begin
          emit_step = 1'b1;
          byte_step = q_item.char_code;
        end
      end
      default: begin
        if (q_item.cls == CLS_DELAY) begin
          emit_step = 1'b1;
          kind_step = 1'b1;
        end
      end
    endcase
  end

  // end of string flushes a field that is still open
  assign res_emit = emit_step ||
                    (q_item.last_char && (mode_step == MODE_DEC || mode_step == MODE_HEX));
  assign res_byte = emit_step ? byte_step : acc_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      cnt  <= '0;
      acc  <= '0;
    end else if (q_pop) begin
      if (q_item.last_char) begin
        mode <= MODE_IDLE;
        cnt  <= '0;
        acc  <= '0;
      end else begin
        mode <= mode_step;
        cnt  <= cnt_step;
        acc  <= acc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= res_emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_emit) begin
      res_item.out_kind <= emit_step && kind_step;
      res_item.out_byte <= res_byte;
    end
  end

endmodule

[sv/escape_string_to_serial_bytes_unit.sv]
// Command string decoder for a serial sender.
// Input channel (char_valid / char_stall / char_item): one character of the
// command string per item, with last_char set on the final one.
// Output channel (res_valid / res_stall / res_item): zero or one result per
// character, either a byte to send (out_kind 0) or a one-second delay
// request (out_kind 1, out_byte 0).
// Forms: [d]..[ddd] decimal, {h}/{hh} hex, 'text' literal, ^ delay.
// Throughput: one character per cycle while res_stall is low. Each character is
// classified in the front stage, waits in a QUEUE_DEPTH-entry queue and is
// parsed by the back stage, whose mode/count/value update is registered.
// Path: the front register loads on the accepting edge, then the queue slot
// is written, then the result register loads when the back stage pops the
// character; a stall can hold the character between any of these.
// Stall: res_stall holds the result register; the back stops popping, the
// queue fills, then char_stall rises. Nothing is dropped or repeated.
// Reset (rst, synchronous): empties the front stage, the queue and the
// result register and returns the parser to idle; no clearing pass.
`include "escape_string_to_serial_bytes_unit_defines.svh"

module escape_string_to_serial_bytes_unit import essb_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  in_item_t  char_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  // front -> queue
  logic          q_push;
  class_item_t   q_in;
  // queue -> back
  logic          q_pop;
  class_item_t   q_out;
  queue_status_t q_stat;

  essb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .q_push     (q_push),
    .q_ready    (!q_stat.full),
    .q_item     (q_in)
  );

  essb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_stat)
  );

  // parser; owns the result register
  essb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_stat.empty),
    .q_pop     (q_pop),
    .q_item    (q_out),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  // a pop only when the result slot is free or draining
  `ESSB_ASSERT_IMPLY(a_pop_slot, clk, rst, q_pop, !res_valid || !res_stall)
  // front never pushes into a full queue
  `ESSB_ASSERT_IMPLY(a_push_room, clk, rst, q_push, !q_stat.full)
  // delay requests carry a zero byte
  `ESSB_ASSERT_IMPLY(a_delay_zero, clk, rst, res_valid && res_item.out_kind, res_item.out_byte == '0)
  // reset leaves no result pending and the queue empty
  `ESSB_ASSERT_NEXT(a_reset_clear, clk, rst, !res_valid && q_stat.empty)

endmodule
